// ----- sv/rcr_pkg.sv -----
// ----------------------------------------------------------------------------
// rcr_pkg - shared constants and types for the cubic ramp derivative core
// Field widths of the exact wide-integer datapath, register indexes and
// the result record.
// ----------------------------------------------------------------------------
package rcr_pkg;

  // fraction bits of the fixed point format
  localparam int FRAC_BITS_DEF = 16;

  // digit width of one partial product
  localparam int DIG_W = 32;

  // quotient bits kept per division, larger quotients saturate
  localparam int QUO_BITS = 34;

  // datapath widths (all magnitudes, unsigned)
  localparam int W_WORD = 32;
  localparam int W_DM   = 32;
  localparam int W_V    = 32;
  localparam int W_SQ   = 64;
  localparam int W_DEN  = 65;
  localparam int W_P    = 65;
  localparam int W_M    = 64;
  localparam int W_VD   = 64;
  localparam int W_D1   = 130;
  localparam int W_PS   = 129;
  localparam int W_MQ   = 128;
  localparam int W_N0   = 128;
  localparam int W_D2   = 195;
  localparam int W_N1   = 161;
  localparam int W_N2A  = 192;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_VELOCITY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_TIMESCALE = 2'd3;

  localparam logic [W_WORD-1:0] TAU_RESET = 32'h0001_0000;

  // number of digits in a word of w bits
  function automatic int digits(input int w);
    return (w + DIG_W - 1) / DIG_W;
  endfunction

  // one result request
  typedef struct packed {
    logic [W_WORD-1:0] func_value;
    logic [W_WORD-1:0] first_deriv;
    logic [W_WORD-1:0] second_deriv;
    logic              zero_denominator;
    logic              saturated;
  } res_t;

endpackage

// ----- sv/rational_cubic_ramp_derivs_core.sv -----
// ----------------------------------------------------------------------------
// rational_cubic_ramp_derivs_core - smoothed cubic ramp with derivatives
// Evaluates value, first and second derivative of a rational cubic ramp
// for each time sample, exactly in wide integers, saturated to Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one sample_time request.
//   Result channel: out_valid / out_stall carry value, both derivatives,
//   the zero denominator flag and the saturation flag.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//   (start value, start time, velocity, decay timescale); write only
//   while no request is in flight.
//   Pipeline: input and time difference stages, one multiply for dt^2,
//   a denominator stage, two layers of wide multipliers (9 and 15 stages,
//   at most one 32x32 partial product per stage) and 35 divider stages.
//   Throughput: one request per cycle while in_stall is low.
//   Reset: configuration returns to its reset values, the pipeline and
//   output stages are emptied.
//   Stall: the result is held in an output register with a skid slot; the
//   pipeline freezes and in_stall rises only once the skid slot is full.
// ----------------------------------------------------------------------------
module rational_cubic_ramp_derivs_core #(
  parameter int FRAC_BITS = rcr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rcr_pkg::W_WORD-1:0]    in_sample_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rcr_pkg::W_WORD-1:0]    out_func_value,
  output logic [rcr_pkg::W_WORD-1:0]    out_first_deriv,
  output logic [rcr_pkg::W_WORD-1:0]    out_second_deriv,
  output logic                          out_zero_denominator,
  output logic                          out_saturated,
  input  logic                          cfg_wr_en,
  input  logic [rcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcr_pkg::W_WORD-1:0]    cfg_wdata
);

  localparam int WW      = rcr_pkg::W_WORD;
  localparam int K       = rcr_pkg::QUO_BITS;
  localparam int W_D0    = rcr_pkg::W_DEN + FRAC_BITS;
  localparam int W_N2    = rcr_pkg::W_N2A + FRAC_BITS + 1;
  localparam int DEPTH_S = rcr_pkg::digits(rcr_pkg::W_DM) * rcr_pkg::digits(rcr_pkg::W_DM);
  localparam int NP_VD   = rcr_pkg::digits(rcr_pkg::W_V) * rcr_pkg::digits(rcr_pkg::W_DM);
  localparam int NP_D1   = rcr_pkg::digits(rcr_pkg::W_DEN) * rcr_pkg::digits(rcr_pkg::W_DEN);
  localparam int NP_PS   = rcr_pkg::digits(rcr_pkg::W_P) * rcr_pkg::digits(rcr_pkg::W_SQ);
  localparam int NP_MQ   = rcr_pkg::digits(rcr_pkg::W_M) * rcr_pkg::digits(rcr_pkg::W_SQ);
  localparam int NP_N0   = rcr_pkg::digits(rcr_pkg::W_VD) * rcr_pkg::digits(rcr_pkg::W_SQ);
  localparam int NP_D2   = rcr_pkg::digits(rcr_pkg::W_D1) * rcr_pkg::digits(rcr_pkg::W_DEN);
  localparam int NP_N1   = rcr_pkg::digits(rcr_pkg::W_PS) * rcr_pkg::digits(rcr_pkg::W_V);
  localparam int NP_N2   = rcr_pkg::digits(rcr_pkg::W_MQ) * rcr_pkg::digits(rcr_pkg::W_VD);
  localparam int MX1A    = (NP_VD > NP_D1) ? NP_VD : NP_D1;
  localparam int MX1B    = (NP_PS > NP_MQ) ? NP_PS : NP_MQ;
  localparam int DEPTH1  = (MX1A > MX1B) ? MX1A : MX1B;
  localparam int MX2A    = (NP_N0 > NP_D2) ? NP_N0 : NP_D2;
  localparam int MX2B    = (NP_N1 > NP_N2) ? NP_N1 : NP_N2;
  localparam int DEPTH2  = (MX2A > MX2B) ? MX2A : MX2B;
  localparam int LAT     = 3 + DEPTH_S + DEPTH1 + DEPTH2 + K + 1;

  // configuration registers
  logic [WW-1:0] start_value_r, start_time_r, ramp_velocity_r, decay_timescale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_value_r     <= '0;
      start_time_r      <= '0;
      ramp_velocity_r   <= '0;
      decay_timescale_r <= rcr_pkg::TAU_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rcr_pkg::REG_START_VALUE:     start_value_r     <= cfg_wdata;
        rcr_pkg::REG_START_TIME:      start_time_r      <= cfg_wdata;
        rcr_pkg::REG_RAMP_VELOCITY:   ramp_velocity_r   <= cfg_wdata;
        rcr_pkg::REG_DECAY_TIMESCALE: decay_timescale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // magnitudes and derived constants of the configuration
  logic [WW-1:0]              vm_mag, tm_mag;
  logic                       vneg;
  logic [rcr_pkg::W_SQ-1:0]   tau_sq_r, tau_sq3_r;

  assign vneg   = ramp_velocity_r[WW-1];
  assign vm_mag = ramp_velocity_r[WW-1] ? (WW'(0) - ramp_velocity_r) : ramp_velocity_r;
  assign tm_mag = decay_timescale_r[WW-1] ? (WW'(0) - decay_timescale_r) : decay_timescale_r;

  always_ff @(posedge clk) begin
    tau_sq_r  <= {32'd0, tm_mag} * {32'd0, tm_mag};
    tau_sq3_r <= tau_sq_r + (tau_sq_r << 1);
  end

  // pipeline advance and valid line
  logic           en;
  logic [LAT-1:0] vld_r;
  logic           skid_valid_r, out_valid_r;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // input register
  logic [WW-1:0] x0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_sample_time;
    end
  end

  // time difference and its magnitude
  logic [WW:0]           dt;
  logic [rcr_pkg::W_DM-1:0] dm1_r;
  logic                  dneg1_r, zero1_r;

  assign dt = {x0_r[WW-1], x0_r} - {start_time_r[WW-1], start_time_r};

  always_ff @(posedge clk) begin
    if (en) begin
      dneg1_r <= dt[WW];
      dm1_r   <= dt[WW] ? rcr_pkg::W_DM'((WW+1)'(0) - dt) : dt[WW-1:0];
      zero1_r <= (dt == '0) && (tm_mag == '0);
    end
  end

  // dt squared
  logic [rcr_pkg::W_SQ-1:0] sq2;
  logic [rcr_pkg::W_DM-1:0] dm2;
  logic                     dneg2, zero2;

  rcr_mul #(
    .WA(rcr_pkg::W_DM), .WB(rcr_pkg::W_DM), .WS(rcr_pkg::W_DM + 2), .DEPTH(DEPTH_S)
  ) u_mul_sq (
    .clk(clk), .en(en), .a(dm1_r), .b(dm1_r),
    .side_in({dneg1_r, zero1_r, dm1_r}), .prod(sq2), .side_out({dneg2, zero2, dm2})
  );

  // denominator and numerator sums
  logic [rcr_pkg::W_DEN-1:0] den3_r;
  logic [rcr_pkg::W_P-1:0]   p3_r;
  logic [rcr_pkg::W_M-1:0]   m3_r;
  logic [rcr_pkg::W_SQ-1:0]  sq3_r;
  logic [rcr_pkg::W_DM-1:0]  dm3_r;
  logic                      sneg3_r, dneg3_r, zero3_r;
  logic                      sgt;

  assign sgt = (sq2 > tau_sq3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      den3_r  <= rcr_pkg::W_DEN'(tau_sq_r) + rcr_pkg::W_DEN'(sq2);
      p3_r    <= rcr_pkg::W_P'(tau_sq3_r) + rcr_pkg::W_P'(sq2);
      m3_r    <= sgt ? (sq2 - tau_sq3_r) : (tau_sq3_r - sq2);
      sneg3_r <= sgt;
      sq3_r   <= sq2;
      dm3_r   <= dm2;
      dneg3_r <= dneg2;
      zero3_r <= zero2;
    end
  end

  // first multiplier layer
  logic [rcr_pkg::W_VD-1:0]  vd4;
  logic [rcr_pkg::W_D1-1:0]  d1_4;
  logic [rcr_pkg::W_PS-1:0]  ps4;
  logic [rcr_pkg::W_MQ-1:0]  mq4;
  logic [rcr_pkg::W_DEN-1:0] den4;
  logic [rcr_pkg::W_SQ-1:0]  sq4;
  logic                      dneg4, zero4, sneg4;

  rcr_mul #(.WA(rcr_pkg::W_V), .WB(rcr_pkg::W_DM), .WS(2), .DEPTH(DEPTH1)) u_mul_vd (
    .clk(clk), .en(en), .a(vm_mag), .b(dm3_r),
    .side_in({dneg3_r, zero3_r}), .prod(vd4), .side_out({dneg4, zero4})
  );

  rcr_mul #(.WA(rcr_pkg::W_DEN), .WB(rcr_pkg::W_DEN), .WS(rcr_pkg::W_DEN), .DEPTH(DEPTH1))
  u_mul_d1 (
    .clk(clk), .en(en), .a(den3_r), .b(den3_r),
    .side_in(den3_r), .prod(d1_4), .side_out(den4)
  );

  rcr_mul #(.WA(rcr_pkg::W_P), .WB(rcr_pkg::W_SQ), .WS(rcr_pkg::W_SQ), .DEPTH(DEPTH1))
  u_mul_ps (
    .clk(clk), .en(en), .a(p3_r), .b(sq3_r),
    .side_in(sq3_r), .prod(ps4), .side_out(sq4)
  );

  rcr_mul #(.WA(rcr_pkg::W_M), .WB(rcr_pkg::W_SQ), .WS(1), .DEPTH(DEPTH1)) u_mul_mq (
    .clk(clk), .en(en), .a(m3_r), .b(tau_sq_r),
    .side_in(sneg3_r), .prod(mq4), .side_out(sneg4)
  );

  // second multiplier layer
  logic [rcr_pkg::W_N0-1:0]  n0_5;
  logic [rcr_pkg::W_D2-1:0]  d2_5;
  logic [rcr_pkg::W_N1-1:0]  n1_5;
  logic [rcr_pkg::W_N2A-1:0] n2a_5;
  logic [rcr_pkg::W_DEN-1:0] den5;
  logic [rcr_pkg::W_D1-1:0]  d1_5;
  logic                      dneg5, zero5, sneg5;

  rcr_mul #(.WA(rcr_pkg::W_VD), .WB(rcr_pkg::W_SQ), .WS(1), .DEPTH(DEPTH2)) u_mul_n0 (
    .clk(clk), .en(en), .a(vd4), .b(sq4),
    .side_in(dneg4), .prod(n0_5), .side_out(dneg5)
  );

  rcr_mul #(.WA(rcr_pkg::W_D1), .WB(rcr_pkg::W_DEN), .WS(rcr_pkg::W_DEN), .DEPTH(DEPTH2))
  u_mul_d2 (
    .clk(clk), .en(en), .a(d1_4), .b(den4),
    .side_in(den4), .prod(d2_5), .side_out(den5)
  );

  rcr_mul #(.WA(rcr_pkg::W_PS), .WB(rcr_pkg::W_V), .WS(rcr_pkg::W_D1 + 1), .DEPTH(DEPTH2))
  u_mul_n1 (
    .clk(clk), .en(en), .a(ps4), .b(vm_mag),
    .side_in({zero4, d1_4}), .prod(n1_5), .side_out({zero5, d1_5})
  );

  rcr_mul #(.WA(rcr_pkg::W_MQ), .WB(rcr_pkg::W_VD), .WS(1), .DEPTH(DEPTH2)) u_mul_n2 (
    .clk(clk), .en(en), .a(mq4), .b(vd4),
    .side_in(sneg4), .prod(n2a_5), .side_out(sneg5)
  );

  // the three divisions
  logic [W_D0-1:0] d0_5;
  logic [W_N2-1:0] n2_5;
  logic [K-1:0]    q0, q1, q2;
  logic            ovf0, ovf1, ovf2, zero6, dneg6, sneg6;

  assign d0_5 = W_D0'(den5) << FRAC_BITS;
  assign n2_5 = W_N2'(n2a_5) << (FRAC_BITS + 1);

  rcr_div #(.WN(rcr_pkg::W_N0), .WD(W_D0), .K(K), .WS(1)) u_div_val (
    .clk(clk), .en(en), .num(n0_5), .den(d0_5), .side_in(zero5),
    .quo(q0), .ovf(ovf0), .side_out(zero6)
  );

  rcr_div #(.WN(rcr_pkg::W_N1), .WD(rcr_pkg::W_D1), .K(K), .WS(1)) u_div_first (
    .clk(clk), .en(en), .num(n1_5), .den(d1_5), .side_in(dneg5),
    .quo(q1), .ovf(ovf1), .side_out(dneg6)
  );

  rcr_div #(.WN(W_N2), .WD(rcr_pkg::W_D2), .K(K), .WS(1)) u_div_second (
    .clk(clk), .en(en), .num(n2_5), .den(d2_5), .side_in(sneg5),
    .quo(q2), .ovf(ovf2), .side_out(sneg6)
  );

  // sign, offset and saturation of one output
  function automatic logic [WW:0] fin_fn(input logic [K+1:0] base, input logic [K-1:0] q,
                                         input logic ovf, input logic neg);
    logic [K+1:0] m;
    logic [K+1:0] s;
    logic [WW:0]  r;
    m = {2'b00, q};
    if (neg) m = (K+2)'(0) - m;
    s = base + m;
    if (ovf) begin
      r = neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff};
    end else if ($signed(s) > $signed((K+2)'(32'h7fff_ffff))) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if ($signed(s) < $signed({{(K-30){1'b1}}, 32'h8000_0000})) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, s[WW-1:0]};
    end
    return r;
  endfunction

  logic [WW:0]    r0, r1, r2;
  rcr_pkg::res_t  res_new;

  assign r0 = fin_fn({{(K+2-WW){start_value_r[WW-1]}}, start_value_r}, q0, ovf0,
                     dneg6 ^ vneg);
  assign r1 = fin_fn('0, q1, ovf1, vneg);
  assign r2 = fin_fn('0, q2, ovf2, !(sneg6 ^ dneg6 ^ vneg));

  always_comb begin
    if (zero6) begin
      res_new = '0;
      res_new.zero_denominator = 1'b1;
    end else begin
      res_new.func_value       = r0[WW-1:0];
      res_new.first_deriv      = r1[WW-1:0];
      res_new.second_deriv     = r2[WW-1:0];
      res_new.zero_denominator = 1'b0;
      res_new.saturated        = r0[WW] | r1[WW] | r2[WW];
    end
  end

  // output register with skid slot
  rcr_pkg::res_t out_r, skid_r;
  logic          push, pop;

  assign push = en && vld_r[LAT-1];
  assign pop  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_r <= skid_r;
    end else if (!out_valid_r || pop) begin
      out_r <= res_new;
    end else if (push) begin
      skid_r <= res_new;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_func_value       = out_r.func_value;
  assign out_first_deriv      = out_r.first_deriv;
  assign out_second_deriv     = out_r.second_deriv;
  assign out_zero_denominator = out_r.zero_denominator;
  assign out_saturated        = out_r.saturated;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a request while the output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid slot filled without a stalled output");

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_denominator) |->
      (!out_saturated && out_func_value == '0 && out_first_deriv == '0 &&
       out_second_deriv == '0))
    else $error("zero denominator result carries non-zero fields");

endmodule

// ----- sv/rcr_mul.sv -----
// ----------------------------------------------------------------------------
// rcr_mul - pipelined wide unsigned multiplier
// One 32x32 partial product is accumulated per stage; extra stages pass the
// sum on so that parallel lanes line up. A side word travels alongside.
// ----------------------------------------------------------------------------
module rcr_mul #(
  parameter int WA    = 32,
  parameter int WB    = 32,
  parameter int WS    = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  input  logic [WS-1:0]    side_in,
  output logic [WA+WB-1:0] prod,
  output logic [WS-1:0]    side_out
);

  localparam int DW  = rcr_pkg::DIG_W;
  localparam int NA  = rcr_pkg::digits(WA);
  localparam int NB  = rcr_pkg::digits(WB);
  localparam int NP  = NA * NB;
  localparam int WAP = NA * DW;
  localparam int WBP = NB * DW;
  localparam int WP  = WAP + WBP;

  logic [WAP-1:0] a_r    [DEPTH];
  logic [WBP-1:0] b_r    [DEPTH];
  logic [WP-1:0]  acc_r  [DEPTH];
  logic [WS-1:0]  side_r [DEPTH];

  genvar s;
  generate
    for (s = 0; s < DEPTH; s++) begin : g_stage
      logic [WAP-1:0] a_src;
      logic [WBP-1:0] b_src;
      logic [WP-1:0]  acc_src;
      logic [WS-1:0]  side_src;
      logic [WP-1:0]  acc_nxt;

      // stage inputs
      if (s == 0) begin : g_first
        assign a_src    = WAP'(a);
        assign b_src    = WBP'(b);
        assign acc_src  = '0;
        assign side_src = side_in;
      end else begin : g_next
        assign a_src    = a_r[s-1];
        assign b_src    = b_r[s-1];
        assign acc_src  = acc_r[s-1];
        assign side_src = side_r[s-1];
      end

      // one partial product per stage, then pass-through
      if (s < NP) begin : g_pp
        localparam int I = s / NB;
        localparam int J = s % NB;
        logic [2*DW-1:0] pp;
        assign pp      = (2*DW)'(a_src[I*DW +: DW]) * (2*DW)'(b_src[J*DW +: DW]);
        assign acc_nxt = acc_src + (WP'(pp) << (DW * (I + J)));
      end else begin : g_pass
        assign acc_nxt = acc_src;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          a_r[s]    <= a_src;
          b_r[s]    <= b_src;
          acc_r[s]  <= acc_nxt;
          side_r[s] <= side_src;
        end
      end
    end
  endgenerate

  assign prod     = acc_r[DEPTH-1][WA+WB-1:0];
  assign side_out = side_r[DEPTH-1];

endmodule

// ----- sv/rcr_div.sv -----
// ----------------------------------------------------------------------------
// rcr_div - pipelined restoring divider with a bounded quotient
// First stage flags a quotient of 2^K or more, then one quotient bit is
// settled per stage by a compare and subtract.
// ----------------------------------------------------------------------------
module rcr_div #(
  parameter int WN = 64,
  parameter int WD = 32,
  parameter int K  = 34,
  parameter int WS = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WN-1:0] num,
  input  logic [WD-1:0] den,
  input  logic [WS-1:0] side_in,
  output logic [K-1:0]  quo,
  output logic          ovf,
  output logic [WS-1:0] side_out
);

  localparam int WR = WD + K;
  localparam int WC = (WN > WR) ? WN : WR;

  logic [WR-1:0] rem_r  [K+1];
  logic [WD-1:0] d_r    [K+1];
  logic [K-1:0]  qt_r   [K+1];
  logic          ovf_r  [K+1];
  logic [WS-1:0] side_r [K+1];

  // range check stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= WR'(num);
      d_r[0]    <= den;
      qt_r[0]   <= '0;
      ovf_r[0]  <= (WC'(num) >= (WC'(den) << K));
      side_r[0] <= side_in;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= K; k++) begin : g_bit
      localparam int B = K - k;
      logic [WR-1:0] trial;
      logic          ge;
      logic [WR-1:0] rem_nxt;
      logic [K-1:0]  qt_nxt;

      // trial subtract of the shifted divisor
      assign trial   = WR'(d_r[k-1]) << B;
      assign ge      = (rem_r[k-1] >= trial);
      assign rem_nxt = ge ? (rem_r[k-1] - trial) : rem_r[k-1];
      assign qt_nxt  = qt_r[k-1] | (K'(ge) << B);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= rem_nxt;
          d_r[k]    <= d_r[k-1];
          qt_r[k]   <= qt_nxt;
          ovf_r[k]  <= ovf_r[k-1];
          side_r[k] <= side_r[k-1];
        end
      end
    end
  endgenerate

  assign quo      = qt_r[K];
  assign ovf      = ovf_r[K];
  assign side_out = side_r[K];

endmodule
